>>> hw/rtl/sbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared constants, widths and control structs of the subband beat detector.
// ----------------------------------------------------------------------------
package sbd_pkg;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int min2(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  localparam int NUM_BANDS        = 32;
  localparam int SPECTRUM_BINS    = 1024;
  localparam int HISTORY_DEPTH    = 64;
  localparam int BEAT_QUEUE_DEPTH = 16;

  localparam int BPB      = SPECTRUM_BINS / NUM_BANDS;
  localparam bit BPB_POW2 = ((BPB & (BPB - 1)) == 0);
  localparam int BPB_LOG  = $clog2(BPB);
  localparam int BPB_CW   = $clog2(BPB + 1);

  localparam int MAG_W    = 16;
  localparam int TIME_W   = 32;
  localparam int BPM_W    = 16;
  localparam int BIDX_W   = 5;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_RATIO   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_WINDOW_MS = 1'd1;
  localparam logic [CFG_W-1:0]     RATIO_RESET  = 16'd384;
  localparam logic [CFG_W-1:0]     WINDOW_RESET = 16'd2000;

  localparam int BAND_W   = $clog2(NUM_BANDS);
  localparam int BANDC_W  = $clog2(NUM_BANDS + 1);
  localparam int BIN_W    = $clog2(SPECTRUM_BINS + 1);
  localparam int SQ_W     = 2 * MAG_W + 1;
  localparam int ACC_W    = SQ_W + BPB_LOG;
  localparam int ENERGY_W = 34;

  localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W      = ENERGY_W + FILL_W;
  localparam int HMEM_DEPTH = NUM_BANDS * HISTORY_DEPTH;
  localparam int HADDR_W    = $clog2(HMEM_DEPTH);

  localparam int QIDX_W     = $clog2(BEAT_QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(BEAT_QUEUE_DEPTH + 1);
  localparam int QMEM_DEPTH = NUM_BANDS * BEAT_QUEUE_DEPTH;
  localparam int QADDR_W    = $clog2(QMEM_DEPTH);

  localparam int BPM_NUM  = 6000000;
  localparam int BPM_MAX  = 65535;
  localparam int NUM_W    = $clog2(BPM_NUM * BEAT_QUEUE_DEPTH);

  localparam int DIV_N_W  = max2(max2(ACC_W, SUM_W), NUM_W);
  localparam int DIV_D_W  = 32;

  localparam int RATIO_FRAC = 8;
  localparam int MUL_SPLIT  = ENERGY_W / 2;
  localparam int PROD_W     = CFG_W + ENERGY_W;

  localparam int RESULT_LIMIT = 32;
  localparam int LAST_RES     = min2(NUM_BANDS, RESULT_LIMIT) - 1;

  typedef struct packed {
    logic bin_en;
    logic e_start;
    logic e_latch;
    logic hist_rd;
    logic hist_upd;
    logic mean_latch;
    logic mul_hi;
    logic mul_lo;
    logic cmp;
    logic push;
    logic q_rd_head;
    logic q_drop;
    logic q_rd_last;
    logic q_span;
    logic bpm_latch;
    logic emit;
  } sbd_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic beat_new;
    logic drop;
    logic cnt_ge2;
    logic span_zero;
    logic out_free;
    logic reported;
    logic last_band;
  } sbd_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/subband_beat_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subband_beat_detector_core
// Subband energy beat detector with per-band tempo estimate.
// ----------------------------------------------------------------------------
// A bin that is not the last of its frame is taken without a stall. The last
// bin starts a pass over all bands, one band after the other, with input
// stalled until the pass ends; each band gives one result. The time a band
// takes grows with q, the number of beat times checked against the window
// (at most 16), and with an energy division when the bin count per band is
// not a power of two. A band that neither pushes a beat time nor holds two
// times skips the tempo division. The pass timing is set by the shared
// bit-serial divider (mean of the history, then the tempo) and the
// single-port beat-time memory.
// Results wait in an output register; a stalled result holds the pass.
// ----------------------------------------------------------------------------
module subband_beat_detector_core
  import sbd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [MAG_W-1:0]     left_magnitude_i,
  input  wire logic [MAG_W-1:0]     right_magnitude_i,
  input  wire logic [TIME_W-1:0]    time_ms_i,
  input  wire logic                 last_bin_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [BIDX_W-1:0]    band_index_o,
  output logic                      beat_flag_o,
  output logic      [ENERGY_W-1:0]  band_energy_o,
  output logic      [BPM_W-1:0]     bpm_centi_o,
  output logic                      bpm_saturated_o,
  output logic                      last_band_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  sbd_cmd_t    cmd;
  sbd_status_t status;

  sbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_bin_i (last_bin_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbd_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .left_magnitude_i  (left_magnitude_i),
    .right_magnitude_i (right_magnitude_i),
    .time_ms_i         (time_ms_i),
    .last_bin_i        (last_bin_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .band_index_o      (band_index_o),
    .beat_flag_o       (beat_flag_o),
    .band_energy_o     (band_energy_o),
    .bpm_centi_o       (bpm_centi_o),
    .bpm_saturated_o   (bpm_saturated_o),
    .last_band_o       (last_band_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/sbd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sbd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module sbd_divider
  import sbd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DIV_N_W-1:0] dividend_i,
  input  wire logic [DIV_D_W-1:0] divisor_i,
  output logic                    busy_o,
  output logic      [DIV_N_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic [DIV_N_W-1:0] quo_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_D_W-1:0] div_q;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  assign rem_sh = {rem_q, quo_q[DIV_N_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIV_N_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], fits};
      rem_q <= fits ? DIV_D_W'(rem_sh - {1'b0, div_q}) : DIV_D_W'(rem_sh);
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

>>> hw/rtl/sbd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_datapath
// Band accumulators, per-band history and beat-queue state, memories,
// shared divider, threshold multiply and the result register.
// ----------------------------------------------------------------------------
module sbd_datapath
  import sbd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sbd_cmd_t              cmd_i,
  output sbd_status_t                status_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic [MAG_W-1:0]      left_magnitude_i,
  input  wire logic [MAG_W-1:0]      right_magnitude_i,
  input  wire logic [TIME_W-1:0]     time_ms_i,
  input  wire logic                  last_bin_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [BIDX_W-1:0]     band_index_o,
  output logic                       beat_flag_o,
  output logic      [ENERGY_W-1:0]   band_energy_o,
  output logic      [BPM_W-1:0]      bpm_centi_o,
  output logic                       bpm_saturated_o,
  output logic                       last_band_o
);

  function automatic logic [QIDX_W-1:0] qwrap(input logic [QCNT_W:0] s);
    logic [QCNT_W:0] r;
    r = (s >= (QCNT_W + 1)'(BEAT_QUEUE_DEPTH)) ? s - (QCNT_W + 1)'(BEAT_QUEUE_DEPTH) : s;
    return QIDX_W'(r);
  endfunction

  logic [CFG_W-1:0] ratio_q;
  logic [CFG_W-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q  <= RATIO_RESET;
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENERGY_RATIO:   ratio_q  <= cfg_data_i;
        CFG_BEAT_WINDOW_MS: window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Bin counting
  logic [BIN_W-1:0]   bin_cnt_q;
  logic [BPB_CW-1:0]  sub_q;
  logic [BANDC_W-1:0] acc_band_q;
  logic [BAND_W-1:0]  band_q;
  logic [TIME_W-1:0]  time_q;
  logic               bin_live;
  logic               band_live;

  assign bin_live  = bin_cnt_q < BIN_W'(SPECTRUM_BINS);
  assign band_live = bin_live && (acc_band_q < BANDC_W'(NUM_BANDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q  <= '0;
      sub_q      <= '0;
      acc_band_q <= '0;
    end else if (cmd_i.bin_en) begin
      if (last_bin_i) begin
        bin_cnt_q  <= '0;
        sub_q      <= '0;
        acc_band_q <= '0;
      end else if (bin_live) begin
        bin_cnt_q <= bin_cnt_q + 1'b1;
        if (sub_q == BPB_CW'(BPB - 1)) begin
          sub_q <= '0;
          if (acc_band_q < BANDC_W'(NUM_BANDS)) begin
            acc_band_q <= acc_band_q + 1'b1;
          end
        end else begin
          sub_q <= sub_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= '0;
    end else if (cmd_i.bin_en && last_bin_i) begin
      band_q <= '0;
    end else if (cmd_i.emit) begin
      band_q <= band_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_en && last_bin_i) begin
      time_q <= time_ms_i;
    end
  end

  // Band accumulators
  logic [ACC_W-1:0]     band_acc_q [NUM_BANDS];
  logic [BAND_W-1:0]    acc_idx;
  logic [ACC_W-1:0]     acc_rd;
  logic [2*MAG_W-1:0]   l_sq;
  logic [2*MAG_W-1:0]   r_sq;
  logic [SQ_W-1:0]      bin_sq;

  assign acc_idx = cmd_i.bin_en ? acc_band_q[BAND_W-1:0] : band_q;
  assign acc_rd  = band_acc_q[acc_idx];
  assign l_sq    = left_magnitude_i * left_magnitude_i;
  assign r_sq    = right_magnitude_i * right_magnitude_i;
  assign bin_sq  = SQ_W'(l_sq) + SQ_W'(r_sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_acc_q[i] <= '0;
      end
    end else if (cmd_i.bin_en && band_live) begin
      band_acc_q[acc_idx] <= acc_rd + ACC_W'(bin_sq);
    end else if (cmd_i.emit) begin
      band_acc_q[acc_idx] <= '0;
    end
  end

  // Per-band state
  logic [FILL_W-1:0]     fill_q  [NUM_BANDS];
  logic [HIST_IDX_W-1:0] head_q  [NUM_BANDS];
  logic [SUM_W-1:0]      sum_q   [NUM_BANDS];
  logic                  seen_q  [NUM_BANDS];
  logic [QIDX_W-1:0]     qhead_q [NUM_BANDS];
  logic [QCNT_W-1:0]     qcnt_q  [NUM_BANDS];

  logic [FILL_W-1:0]     cur_fill;
  logic [HIST_IDX_W-1:0] cur_head;
  logic [SUM_W-1:0]      cur_sum;
  logic                  cur_seen;
  logic [QIDX_W-1:0]     cur_qhead;
  logic [QCNT_W-1:0]     cur_qcnt;
  logic                  beat_d;

  assign cur_fill  = fill_q[band_q];
  assign cur_head  = head_q[band_q];
  assign cur_sum   = sum_q[band_q];
  assign cur_seen  = seen_q[band_q];
  assign cur_qhead = qhead_q[band_q];
  assign cur_qcnt  = qcnt_q[band_q];

  // History ring
  logic [ENERGY_W-1:0]   energy_q;
  logic [ENERGY_W-1:0]   hist_rdata;
  logic [HADDR_W-1:0]    hist_addr;
  logic                  hist_full;
  logic [SUM_W-1:0]      sum_new;
  logic [FILL_W-1:0]     fill_new;
  logic [HIST_IDX_W-1:0] head_new;

  assign hist_addr = HADDR_W'(band_q) * HADDR_W'(HISTORY_DEPTH) + HADDR_W'(cur_head);
  assign hist_full = cur_fill >= FILL_W'(HISTORY_DEPTH);
  assign sum_new   = cur_sum - (hist_full ? SUM_W'(hist_rdata) : '0) + SUM_W'(energy_q);
  assign fill_new  = hist_full ? cur_fill : cur_fill + 1'b1;
  assign head_new  = (cur_head == HIST_IDX_W'(HISTORY_DEPTH - 1)) ? '0 : cur_head + 1'b1;

  sbd_ram #(
    .WIDTH (ENERGY_W),
    .DEPTH (HMEM_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_upd),
    .re_i    (cmd_i.hist_rd),
    .addr_i  (hist_addr),
    .wdata_i (energy_q),
    .rdata_o (hist_rdata)
  );

  // Beat-time queue
  logic [TIME_W-1:0]  q_rdata;
  logic [TIME_W-1:0]  first_q;
  logic [QADDR_W-1:0] q_addr;
  logic [QIDX_W-1:0]  q_idx;
  logic               q_full;
  logic [QIDX_W-1:0]  head1;
  logic [QCNT_W-1:0]  cnt1;
  logic [QIDX_W-1:0]  tail;
  logic [QIDX_W-1:0]  last_idx;
  logic [QIDX_W-1:0]  head_inc;
  logic [TIME_W-1:0]  span;

  assign head_inc = (cur_qhead == QIDX_W'(BEAT_QUEUE_DEPTH - 1)) ? '0 : cur_qhead + 1'b1;
  assign q_full   = cur_qcnt >= QCNT_W'(BEAT_QUEUE_DEPTH);
  assign head1    = q_full ? head_inc : cur_qhead;
  assign cnt1     = q_full ? QCNT_W'(BEAT_QUEUE_DEPTH - 1) : cur_qcnt;
  assign tail     = qwrap((QCNT_W + 1)'(head1) + (QCNT_W + 1)'(cnt1));
  assign last_idx = qwrap((QCNT_W + 1)'(cur_qhead) + (QCNT_W + 1)'(cur_qcnt) - 1'b1);
  assign q_idx    = cmd_i.push ? tail : (cmd_i.q_rd_last ? last_idx : cur_qhead);
  assign q_addr   = QADDR_W'(band_q) * QADDR_W'(BEAT_QUEUE_DEPTH) + QADDR_W'(q_idx);
  assign span     = q_rdata - first_q;

  sbd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (QMEM_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .re_i    (cmd_i.q_rd_head | cmd_i.q_rd_last),
    .addr_i  (q_addr),
    .wdata_i (time_q),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_rd_last) begin
      first_q <= q_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        fill_q[i]  <= '0;
        head_q[i]  <= '0;
        sum_q[i]   <= '0;
        seen_q[i]  <= 1'b0;
        qhead_q[i] <= '0;
        qcnt_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.hist_upd) begin
        fill_q[band_q] <= fill_new;
        head_q[band_q] <= head_new;
        sum_q[band_q]  <= sum_new;
      end
      if (cmd_i.cmp) begin
        seen_q[band_q] <= beat_d;
      end
      if (cmd_i.push) begin
        qhead_q[band_q] <= head1;
        qcnt_q[band_q]  <= cnt1 + 1'b1;
      end else if (cmd_i.q_drop) begin
        qhead_q[band_q] <= head_inc;
        qcnt_q[band_q]  <= cur_qcnt - 1'b1;
      end
    end
  end

  // Shared divider
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic               div_start;
  logic               div_busy;
  logic [DIV_N_W-1:0] quo;
  logic               span_zero;

  assign span_zero = span == '0;
  assign div_start = cmd_i.e_start | cmd_i.hist_upd | (cmd_i.q_span & !span_zero);

  always_comb begin
    if (cmd_i.e_start) begin
      div_n = DIV_N_W'(acc_rd);
      div_d = DIV_D_W'(BPB);
    end else if (cmd_i.hist_upd) begin
      div_n = DIV_N_W'(sum_new);
      div_d = DIV_D_W'(fill_new);
    end else begin
      div_n = DIV_N_W'(BPM_NUM) * DIV_N_W'(cur_qcnt - 1'b1);
      div_d = DIV_D_W'(span);
    end
  end

  sbd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // Energy, mean and threshold
  logic [ENERGY_W-1:0] mean_q;
  logic [PROD_W-1:0]   prod_q;
  logic                beat_q;
  logic [BPM_W-1:0]    bpm_q;
  logic                sat_q;

  assign beat_d = PROD_W'({energy_q, {RATIO_FRAC{1'b0}}}) > prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.e_latch) begin
      if (BPB_POW2) begin
        energy_q <= ENERGY_W'(acc_rd >> BPB_LOG);
      end else begin
        energy_q <= quo[ENERGY_W-1:0];
      end
    end
    if (cmd_i.mean_latch) begin
      mean_q <= quo[ENERGY_W-1:0];
    end
    if (cmd_i.mul_hi) begin
      prod_q <= (PROD_W'(ratio_q) * PROD_W'(mean_q[ENERGY_W-1:MUL_SPLIT])) << MUL_SPLIT;
    end else if (cmd_i.mul_lo) begin
      prod_q <= prod_q + PROD_W'(ratio_q) * PROD_W'(mean_q[MUL_SPLIT-1:0]);
    end
    if (cmd_i.cmp) begin
      beat_q <= beat_d;
      bpm_q  <= '0;
      sat_q  <= 1'b0;
    end else if (cmd_i.q_span && span_zero) begin
      bpm_q <= BPM_W'(BPM_MAX);
      sat_q <= 1'b1;
    end else if (cmd_i.bpm_latch) begin
      if (quo > DIV_N_W'(BPM_MAX)) begin
        bpm_q <= BPM_W'(BPM_MAX);
        sat_q <= 1'b1;
      end else begin
        bpm_q <= quo[BPM_W-1:0];
      end
    end
  end

  // Result register
  logic out_valid_q;
  logic out_free;
  logic reported;
  logic out_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign reported = (7'(band_q) < 7'(RESULT_LIMIT));
  assign out_load = cmd_i.emit && reported;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      band_index_o    <= BIDX_W'(band_q);
      beat_flag_o     <= beat_q;
      band_energy_o   <= energy_q;
      bpm_centi_o     <= bpm_q;
      bpm_saturated_o <= sat_q;
      last_band_o     <= (7'(band_q) == 7'(LAST_RES));
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.div_busy  = div_busy;
  assign status_o.beat_new  = beat_d & !cur_seen;
  assign status_o.drop      = (cur_qcnt != '0) &&
                              ((time_q - q_rdata) > TIME_W'(window_q));
  assign status_o.cnt_ge2   = cur_qcnt >= QCNT_W'(2);
  assign status_o.span_zero = span_zero;
  assign status_o.out_free  = out_free;
  assign status_o.reported  = reported;
  assign status_o.last_band = band_q == BAND_W'(NUM_BANDS - 1);

endmodule
`default_nettype wire

>>> hw/rtl/sbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_ctrl
// Sequencer for bin intake and the per-band frame-end pass.
// ----------------------------------------------------------------------------
module sbd_ctrl
  import sbd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        last_bin_i,
  output logic             in_stall_o,
  input  wire sbd_status_t status_i,
  output sbd_cmd_t         cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ENERGY   = 4'd1;
  localparam logic [3:0] S_EDIV     = 4'd2;
  localparam logic [3:0] S_HIST     = 4'd3;
  localparam logic [3:0] S_MDIV     = 4'd4;
  localparam logic [3:0] S_MULHI    = 4'd5;
  localparam logic [3:0] S_MULLO    = 4'd6;
  localparam logic [3:0] S_CMP      = 4'd7;
  localparam logic [3:0] S_PUSH     = 4'd8;
  localparam logic [3:0] S_DROP_RD  = 4'd9;
  localparam logic [3:0] S_DROP_CHK = 4'd10;
  localparam logic [3:0] S_QRD1     = 4'd11;
  localparam logic [3:0] S_QRD2     = 4'd12;
  localparam logic [3:0] S_QSPAN    = 4'd13;
  localparam logic [3:0] S_BDIV     = 4'd14;
  localparam logic [3:0] S_EMIT     = 4'd15;

  logic [3:0] state_q;
  logic [3:0] state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.bin_en = in_valid_i;
        if (in_valid_i && last_bin_i) begin
          state_d = S_ENERGY;
        end
      end
      S_ENERGY: begin
        if (BPB_POW2) begin
          cmd_o.e_latch = 1'b1;
          cmd_o.hist_rd = 1'b1;
          state_d       = S_HIST;
        end else begin
          cmd_o.e_start = 1'b1;
          state_d       = S_EDIV;
        end
      end
      S_EDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.e_latch = 1'b1;
          cmd_o.hist_rd = 1'b1;
          state_d       = S_HIST;
        end
      end
      S_HIST: begin
        cmd_o.hist_upd = 1'b1;
        state_d        = S_MDIV;
      end
      S_MDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.mean_latch = 1'b1;
          state_d          = S_MULHI;
        end
      end
      S_MULHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_MULLO;
      end
      S_MULLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = status_i.beat_new ? S_PUSH : S_QRD1;
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_DROP_RD;
      end
      S_DROP_RD: begin
        cmd_o.q_rd_head = 1'b1;
        state_d         = S_DROP_CHK;
      end
      S_DROP_CHK: begin
        // drop aged times one per read until the oldest is in the window
        if (status_i.drop) begin
          cmd_o.q_drop = 1'b1;
          state_d      = S_DROP_RD;
        end else begin
          state_d = S_QRD1;
        end
      end
      S_QRD1: begin
        if (status_i.cnt_ge2) begin
          cmd_o.q_rd_head = 1'b1;
          state_d         = S_QRD2;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_QRD2: begin
        cmd_o.q_rd_last = 1'b1;
        state_d         = S_QSPAN;
      end
      S_QSPAN: begin
        cmd_o.q_span = 1'b1;
        state_d      = status_i.span_zero ? S_EMIT : S_BDIV;
      end
      S_BDIV: begin
        if (!status_i.div_busy) begin
          cmd_o.bpm_latch = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free || !status_i.reported) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.last_band ? S_IDLE : S_ENERGY;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
`default_nettype wire

>>> hw/rtl/sbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbd_checker
// Port-level checks of the beat detector result stream.
// ----------------------------------------------------------------------------
module sbd_checker
  import sbd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [BIDX_W-1:0]   band_index_o,
  input wire logic [ENERGY_W-1:0] band_energy_o,
  input wire logic [BPM_W-1:0]    bpm_centi_o,
  input wire logic                bpm_saturated_o,
  input wire logic                last_band_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(band_energy_o) &&
    $stable(band_index_o))
    else $error("stalled result changed");

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bpm_saturated_o |-> bpm_centi_o == BPM_W'(BPM_MAX))
    else $error("saturated tempo not at full scale");

  a_zero_unsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bpm_centi_o == '0) |-> !bpm_saturated_o)
    else $error("zero tempo flagged saturated");

  a_last_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_band_o |-> band_index_o == BIDX_W'(LAST_RES))
    else $error("last band flag on wrong band");

endmodule

bind subband_beat_detector_core sbd_checker u_sbd_checker (.*);
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subband beat detector core. A behavioral copy
// of the band energy, history mean, beat edge, beat-time queue and tempo
// logic predicts every band result. Results are checked in order while both
// sides of the block idle at random in all but the last test.
// ----------------------------------------------------------------------------
module tb_top;
  import sbd_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE_CYCLES = 300;
  localparam longint unsigned E_MASK = 64'h3_FFFF_FFFF;

  typedef struct packed {
    logic [BIDX_W-1:0]   band;
    logic                beat;
    logic [ENERGY_W-1:0] energy;
    logic [BPM_W-1:0]    bpm;
    logic                sat;
    logic                lastb;
  } band_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [MAG_W-1:0]     left_magnitude_i = '0;
  logic [MAG_W-1:0]     right_magnitude_i = '0;
  logic [TIME_W-1:0]    time_ms_i = '0;
  logic                 last_bin_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [BIDX_W-1:0]    band_index_o;
  logic                 beat_flag_o;
  logic [ENERGY_W-1:0]  band_energy_o;
  logic [BPM_W-1:0]     bpm_centi_o;
  logic                 bpm_saturated_o;
  logic                 last_band_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  subband_beat_detector_core dut (.*);

  // predictor state
  int unsigned       ratio_q = RATIO_RESET;
  int unsigned       window_q = WINDOW_RESET;
  int unsigned       bin_cnt;
  longint unsigned   band_acc [NUM_BANDS];
  longint unsigned   hist [NUM_BANDS][HISTORY_DEPTH];
  int unsigned       hist_fill [NUM_BANDS];
  int unsigned       hist_head [NUM_BANDS];
  longint unsigned   hist_sum [NUM_BANDS];
  bit                beat_seen [NUM_BANDS];
  int unsigned       beat_ts [NUM_BANDS][BEAT_QUEUE_DEPTH];
  int unsigned       bq_head [NUM_BANDS];
  int unsigned       bq_cnt [NUM_BANDS];

  band_result_t      pending_results [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       err_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       stamp_ms = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // outputs and stall are stable at the falling edge; a request seen here
  // completes at the next rising edge
  always @(negedge clk_i) begin
    band_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result for band %0d", band_index_o);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (band_index_o !== exp_r.band) begin
          $error("band_index exp %0d got %0d", exp_r.band, band_index_o);
          err_cnt++;
        end
        if (beat_flag_o !== exp_r.beat) begin
          $error("beat_flag exp %0d got %0d", exp_r.beat, beat_flag_o);
          err_cnt++;
        end
        if (band_energy_o !== exp_r.energy) begin
          $error("band_energy exp %0d got %0d", exp_r.energy, band_energy_o);
          err_cnt++;
        end
        if (bpm_centi_o !== exp_r.bpm) begin
          $error("bpm_centi exp %0d got %0d", exp_r.bpm, bpm_centi_o);
          err_cnt++;
        end
        if (bpm_saturated_o !== exp_r.sat) begin
          $error("bpm_saturated exp %0d got %0d", exp_r.sat, bpm_saturated_o);
          err_cnt++;
        end
        if (last_band_o !== exp_r.lastb) begin
          $error("last_band exp %0d got %0d", exp_r.lastb, last_band_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic predict_bin(input int unsigned l, input int unsigned r,
                             input int unsigned t, input bit last);
    longint unsigned energy, mean, v;
    int unsigned h, first_t, last_t, span;
    bit beat;
    band_result_t res;
    if (bin_cnt < SPECTRUM_BINS) begin
      band_acc[bin_cnt / BPB] += longint'(l) * l + longint'(r) * r;
      bin_cnt++;
    end
    if (!last) return;
    for (int b = 0; b < NUM_BANDS; b++) begin
      energy = (band_acc[b] / BPB) & E_MASK;
      h = hist_head[b];
      if (hist_fill[b] >= HISTORY_DEPTH) hist_sum[b] -= hist[b][h];
      else hist_fill[b]++;
      hist[b][h] = energy;
      hist_sum[b] += energy;
      hist_head[b] = (h + 1) % HISTORY_DEPTH;
      mean = hist_sum[b] / hist_fill[b];
      beat = (energy << 8) > longint'(ratio_q) * mean;
      if (beat && !beat_seen[b]) begin
        beat_seen[b] = 1'b1;
        if (bq_cnt[b] >= BEAT_QUEUE_DEPTH) begin
          bq_head[b] = (bq_head[b] + 1) % BEAT_QUEUE_DEPTH;
          bq_cnt[b] = BEAT_QUEUE_DEPTH - 1;
        end
        beat_ts[b][(bq_head[b] + bq_cnt[b]) % BEAT_QUEUE_DEPTH] = t;
        bq_cnt[b]++;
        // drop beat times that fell out of the window
        while (bq_cnt[b] > 0 && (t - beat_ts[b][bq_head[b]]) > window_q) begin
          bq_head[b] = (bq_head[b] + 1) % BEAT_QUEUE_DEPTH;
          bq_cnt[b]--;
        end
      end else if (!beat) begin
        beat_seen[b] = 1'b0;
      end
      res = '0;
      if (bq_cnt[b] >= 2) begin
        first_t = beat_ts[b][bq_head[b]];
        last_t = beat_ts[b][(bq_head[b] + bq_cnt[b] - 1) % BEAT_QUEUE_DEPTH];
        span = last_t - first_t;
        if (span == 0) begin
          res.bpm = BPM_MAX;
          res.sat = 1'b1;
        end else begin
          v = (longint'(BPM_NUM) * (bq_cnt[b] - 1)) / span;
          if (v > BPM_MAX) begin
            v = BPM_MAX;
            res.sat = 1'b1;
          end
          res.bpm = v[BPM_W-1:0];
        end
      end
      band_acc[b] = 0;
      res.band = b[BIDX_W-1:0];
      res.beat = beat;
      res.energy = energy[ENERGY_W-1:0];
      res.lastb = (b == NUM_BANDS - 1);
      pending_results.push_back(res);
    end
    bin_cnt = 0;
  endtask

  // send one bin; returns at the rising edge that took the request
  task automatic send_bin(input int unsigned l, input int unsigned r,
                          input int unsigned t, input bit last);
    bit took;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_magnitude_i <= l[MAG_W-1:0];
    right_magnitude_i <= r[MAG_W-1:0];
    time_ms_i <= t;
    last_bin_i <= last;
    predict_bin(l, r, t, last);
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ENERGY_RATIO) ratio_q = val & 16'hFFFF;
    else window_q = val & 16'hFFFF;
    @(posedge clk_i);
  endtask

  // one frame of n bins; loud frames tend to raise beats
  task automatic send_frame(input int n, input bit loud);
    int unsigned hi;
    hi = loud ? 65535 : 255;
    for (int i = 0; i < n - 1; i++)
      send_bin($urandom_range(hi), $urandom_range(hi), $urandom, 1'b0);
    stamp_ms += $urandom_range(0, 700);
    send_bin($urandom_range(hi), $urandom_range(hi), stamp_ms, 1'b1);
  endtask

  task automatic test_directed_extremes();
    send_bin(0, 0, 0, 1'b1);
    send_bin(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_bin(16'hFFFF, 0, 32'h5555_5555, 1'b0);
    send_bin(0, 16'hFFFF, 32'hAAAA_AAAA, 1'b1);
    send_bin(16'h8000, 16'h0001, 100, 1'b1);
    send_bin(1, 1, 200, 1'b1);
    wait_idle();
  endtask

  // single-bin frames alternate loud and quiet so band 0 beats every other
  // frame, then 3-bin frames; covers saturation, time wrap and a full queue
  task automatic test_tempo_cases();
    write_cfg(CFG_ENERGY_RATIO, 0);
    write_cfg(CFG_BEAT_WINDOW_MS, 16'hFFFF);
    stamp_ms = 32'hFFFF_FF00;
    for (int i = 0; i < 44; i++) begin
      if (i < 8) stamp_ms += 1;
      else if (i >= 10) stamp_ms += 150;
      send_bin((i % 2) ? 0 : 16'hFFFF, (i % 2) ? 0 : 16'h1234, stamp_ms, 1'b1);
    end
    wait_idle();
    write_cfg(CFG_BEAT_WINDOW_MS, 0);
    for (int i = 0; i < 6; i++) begin
      stamp_ms += 10;
      send_bin((i % 2) ? 0 : 16'hFFFF, 0, stamp_ms, 1'b1);
    end
    wait_idle();
    write_cfg(CFG_ENERGY_RATIO, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_frame(3, i % 2 == 0);
    wait_idle();
  endtask

  task automatic test_random_frames(input int items, input int unsigned ratio,
                                    input int unsigned window);
    int sent;
    int n;
    write_cfg(CFG_ENERGY_RATIO, ratio);
    write_cfg(CFG_BEAT_WINDOW_MS, window);
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      if ($urandom_range(19) == 0) stamp_ms = $urandom;
      send_frame(n, $urandom_range(99) < 35);
      sent += n;
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    send_idle_pct = 27;
    recv_idle_pct = 87;
    test_directed_extremes();
    test_tempo_cases();
    test_random_frames(80, RATIO_RESET, WINDOW_RESET);
    send_idle_pct = 87;
    recv_idle_pct = 27;
    test_random_frames(80, 256 + $urandom_range(255), $urandom_range(300, 5000));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(80, $urandom_range(16'hFFFF) % 1024, $urandom_range(16'hFFFF));
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
